/* rtl/console_number_formatter_top_defines.svh */
// Assertion macros used by the formatter top level.
// Depends on a clk and an arst_n being visible where a macro is used.
`ifndef CONSOLE_NUMBER_FORMATTER_TOP_DEFINES_SVH
`define CONSOLE_NUMBER_FORMATTER_TOP_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define CNF_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define CNF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/cnf_pkg.sv */
// Shared types, codes and constants of the console number formatter.
// No dependencies; used by every RTL module of the block.
package cnf_pkg;

	localparam int NUM_CELLS = 20;
	localparam int DIGIT_W   = 4;
	localparam int WORD_W    = NUM_CELLS * DIGIT_W;
	localparam int VALUE_W   = 64;
	localparam int CNT_W     = 5;
	localparam int BITCNT_W  = 6;

	typedef enum logic [1:0] {
		FUNC_CHAR  = 2'd0,
		FUNC_HEX32 = 2'd1,
		FUNC_HEX64 = 2'd2,
		FUNC_DEC   = 2'd3
	} func_t;

	localparam logic [7:0] ASCII_CR   = 8'h0D;
	localparam logic [7:0] ASCII_LF   = 8'h0A;
	localparam logic [7:0] ASCII_ZERO = 8'h30;
	localparam logic [7:0] ASCII_X    = 8'h78;

	localparam logic [CNT_W-1:0]    HEX32_NIBS = 5'd8;
	localparam logic [CNT_W-1:0]    HEX64_NIBS = 5'd16;
	localparam logic [CNT_W-1:0]    DEC_DIGITS = 5'd20;
	localparam logic [BITCNT_W-1:0] CONV_LAST  = 6'd63;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_LOAD,
		CELL_DABBLE,
		CELL_SHIFT
	} cell_mode_t;

	typedef struct packed {
		cell_mode_t mode;
		logic       bit_in;
	} chain_ctrl_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHAR,
		ST_PFX0,
		ST_PFX1,
		ST_CONV,
		ST_SKIP,
		ST_EMIT
	} state_t;

	// Lowercase hex digit; decimal digits map the same way.
	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		logic [7:0] ext;
		ext = {4'h0, nib};
		if (nib < 4'd10) begin
			hex_char = ASCII_ZERO + ext;
		end else begin
			hex_char = 8'h57 + ext;
		end
	endfunction

endpackage

/* rtl/console_number_formatter_top.sv */
// Top level of the console number formatter: request channel, control FSM,
// output register. Uses cnf_pkg, cnf_digit_chain and the assertion macro header.
//
// Usage
//   Input channel (in_valid / in_stall, payload func and value) takes one
//   request; output channel (out_valid / out_stall, payload ascii_char and last)
//   gives its bytes one a cycle unless stalled, last set on the run's final byte.
//   One request is worked at a time: in_stall is high from acceptance until the
//   final byte has been placed in the output register. The output register
//   parts the two sides, so the next request is taken while that byte waits.
//   Steps per request: a character gives one byte, or CR then LF for an LF;
//   hex32 and hex64 send 0 and x, then their nibbles, one byte a cycle from the
//   cells while the output is not stalled; decimal runs the bit-serial conversion
//   through the row of twenty BCD cells (one input bit per cycle), drops the
//   leading zero digits one a cycle, finds the first digit to send and sends
//   the digits; the dropped and the sent digits are twenty in all.
//   Each byte is registered and shows on the output the cycle after it is formed.
//   A stalled output holds its byte and freezes the sequencer; the conversion
//   and zero-skip phases run on regardless.
//   Reset clears the FSM and the output valid flag; no item is in flight after.
`include "console_number_formatter_top_defines.svh"

module console_number_formatter_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  func,
	input  logic [63:0] value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  ascii_char,
	output logic        last
);

	cnf_pkg::state_t    state_q, state_d;
	cnf_pkg::func_t     func_in;
	cnf_pkg::chain_ctrl_t chain_ctrl;

	logic [cnf_pkg::VALUE_W-1:0]  value_q;
	logic [cnf_pkg::BITCNT_W-1:0] bitcnt_q;
	logic [cnf_pkg::CNT_W-1:0]    cnt_q;
	logic [7:0]                   char_q;
	logic                         need_cr_q;
	logic                         out_valid_q;
	logic [7:0]                   ascii_char_q;
	logic                         last_q;

	logic [cnf_pkg::WORD_W-1:0]   load_word;
	logic [3:0]                   top_digit;
	logic                         out_free;
	logic                         in_fire;
	logic                         out_load;
	logic [7:0]                   out_char;
	logic                         out_last;

	assign func_in   = cnf_pkg::func_t'(func);
	assign in_stall  = (state_q != cnf_pkg::ST_IDLE);
	assign in_fire   = in_valid && !in_stall;
	// Output slot can take a byte when empty or when its byte leaves now.
	assign out_free  = !out_valid_q || !out_stall;

	assign out_valid  = out_valid_q;
	assign ascii_char = ascii_char_q;
	assign last       = last_q;

	// Hex nibbles go straight into the top cells, most significant on top.
	always_comb begin
		case (func_in)
			cnf_pkg::FUNC_HEX64:
				load_word = {value, {(cnf_pkg::WORD_W - cnf_pkg::VALUE_W){1'b0}}};
			cnf_pkg::FUNC_HEX32:
				load_word = {value[31:0], {(cnf_pkg::WORD_W - 32){1'b0}}};
			default:
				load_word = '0;
		endcase
	end

	cnf_digit_chain u_chain (
		.clk       (clk),
		.ctrl      (chain_ctrl),
		.load_word (load_word),
		.top_digit (top_digit)
	);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			cnf_pkg::ST_IDLE: begin
				if (in_valid) begin
					case (func_in)
						cnf_pkg::FUNC_CHAR:  state_d = cnf_pkg::ST_CHAR;
						cnf_pkg::FUNC_HEX32: state_d = cnf_pkg::ST_PFX0;
						cnf_pkg::FUNC_HEX64: state_d = cnf_pkg::ST_PFX0;
						default:             state_d = cnf_pkg::ST_CONV;
					endcase
				end
			end
			cnf_pkg::ST_CHAR: begin
				if (out_free && !need_cr_q) state_d = cnf_pkg::ST_IDLE;
			end
			cnf_pkg::ST_PFX0: begin
				if (out_free) state_d = cnf_pkg::ST_PFX1;
			end
			cnf_pkg::ST_PFX1: begin
				if (out_free) state_d = cnf_pkg::ST_EMIT;
			end
			cnf_pkg::ST_CONV: begin
				if (bitcnt_q == '0) state_d = cnf_pkg::ST_SKIP;
			end
			cnf_pkg::ST_SKIP: begin
				if (top_digit != 4'h0 || cnt_q == 5'd1) state_d = cnf_pkg::ST_EMIT;
			end
			cnf_pkg::ST_EMIT: begin
				if (out_free && cnt_q == 5'd1) state_d = cnf_pkg::ST_IDLE;
			end
			default: state_d = cnf_pkg::ST_IDLE;
		endcase
	end

	// Outputs of the FSM: cell commands and the byte to register.
	always_comb begin
		chain_ctrl.mode   = cnf_pkg::CELL_HOLD;
		chain_ctrl.bit_in = value_q[cnf_pkg::VALUE_W-1];
		out_load          = 1'b0;
		out_char          = 8'h00;
		out_last          = 1'b0;
		case (state_q)
			cnf_pkg::ST_IDLE: begin
				if (in_valid) chain_ctrl.mode = cnf_pkg::CELL_LOAD;
			end
			cnf_pkg::ST_CHAR: begin
				out_load = out_free;
				out_char = need_cr_q ? cnf_pkg::ASCII_CR : char_q;
				out_last = !need_cr_q;
			end
			cnf_pkg::ST_PFX0: begin
				out_load = out_free;
				out_char = cnf_pkg::ASCII_ZERO;
			end
			cnf_pkg::ST_PFX1: begin
				out_load = out_free;
				out_char = cnf_pkg::ASCII_X;
			end
			cnf_pkg::ST_CONV: begin
				chain_ctrl.mode = cnf_pkg::CELL_DABBLE;
			end
			cnf_pkg::ST_SKIP: begin
				// Drop a leading zero, but always keep the units digit.
				if (top_digit == 4'h0 && cnt_q != 5'd1) chain_ctrl.mode = cnf_pkg::CELL_SHIFT;
			end
			cnf_pkg::ST_EMIT: begin
				out_load = out_free;
				out_char = cnf_pkg::hex_char(top_digit);
				out_last = (cnt_q == 5'd1);
				if (out_free) chain_ctrl.mode = cnf_pkg::CELL_SHIFT;
			end
			default: begin
				out_load = 1'b0;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= cnf_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
			need_cr_q   <= 1'b0;
			cnt_q       <= '0;
			bitcnt_q    <= '0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (in_fire) begin
				need_cr_q <= (func_in == cnf_pkg::FUNC_CHAR) && (value[7:0] == cnf_pkg::ASCII_LF);
				bitcnt_q  <= cnf_pkg::CONV_LAST;
				case (func_in)
					cnf_pkg::FUNC_HEX32: cnt_q <= cnf_pkg::HEX32_NIBS;
					cnf_pkg::FUNC_HEX64: cnt_q <= cnf_pkg::HEX64_NIBS;
					default:             cnt_q <= cnf_pkg::DEC_DIGITS;
				endcase
			end else begin
				if (state_q == cnf_pkg::ST_CHAR && out_free) need_cr_q <= 1'b0;
				if (state_q == cnf_pkg::ST_CONV) bitcnt_q <= bitcnt_q - 6'd1;
				if (chain_ctrl.mode == cnf_pkg::CELL_SHIFT) cnt_q <= cnt_q - 5'd1;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			char_q  <= value[7:0];
			value_q <= value;
		end else if (state_q == cnf_pkg::ST_CONV) begin
			value_q <= {value_q[cnf_pkg::VALUE_W-2:0], 1'b0};
		end
		if (out_load) begin
			ascii_char_q <= out_char;
			last_q       <= out_last;
		end
	end

	`CNF_ASSERT_NEXT(a_conv_ends, (state_q == cnf_pkg::ST_CONV && bitcnt_q == '0), (state_q == cnf_pkg::ST_SKIP), "conversion did not hand over to digit skip")
	`CNF_ASSERT_NOW(a_cnt_live, (state_q == cnf_pkg::ST_SKIP || state_q == cnf_pkg::ST_EMIT), (cnt_q != '0), "digit count ran out while sending")
	`CNF_ASSERT_NEXT(a_last_ends_run, (out_load && out_last), (state_q == cnf_pkg::ST_IDLE), "final byte formed but request still in progress")
	`CNF_ASSERT_NEXT(a_prefix_x, (state_q == cnf_pkg::ST_PFX1 && out_free), (out_valid_q && ascii_char_q == cnf_pkg::ASCII_X && !last_q), "hex prefix byte wrong")

endmodule

/* rtl/cnf_bcd_cell.sv */
// One digit cell of the formatter's chain: a 4-bit digit that holds, loads,
// runs one add-3-and-shift step, or takes its lower neighbour's digit. Uses cnf_pkg.
module cnf_bcd_cell (
	input  logic               clk,
	input  cnf_pkg::chain_ctrl_t ctrl,
	input  logic [3:0]         load_nib,
	input  logic               carry_in,
	input  logic [3:0]         nib_in,
	output logic [3:0]         digit,
	output logic               carry_out
);

	logic [3:0] digit_q;
	logic [3:0] adj;

	// Correct the digit before the shift so it never passes nine.
	assign adj       = (digit_q >= 4'd5) ? (digit_q + 4'd3) : digit_q;
	assign carry_out = adj[3];
	assign digit     = digit_q;

	always_ff @(posedge clk) begin
		case (ctrl.mode)
			cnf_pkg::CELL_LOAD:   digit_q <= load_nib;
			cnf_pkg::CELL_DABBLE: digit_q <= {adj[2:0], carry_in};
			cnf_pkg::CELL_SHIFT:  digit_q <= nib_in;
			default:              digit_q <= digit_q;
		endcase
	end

endmodule

/* rtl/cnf_digit_chain.sv */
// Row of digit cells: parallel load, binary-to-BCD conversion one bit a cycle and a
// digit-wide shift toward the top cell for output. Uses cnf_pkg, cnf_bcd_cell.
module cnf_digit_chain (
	input  logic                        clk,
	input  cnf_pkg::chain_ctrl_t        ctrl,
	input  logic [cnf_pkg::WORD_W-1:0]  load_word,
	output logic [3:0]                  top_digit
);

	logic [3:0] digit [cnf_pkg::NUM_CELLS];
	logic       carry [cnf_pkg::NUM_CELLS];

	for (genvar i = 0; i < cnf_pkg::NUM_CELLS; i++) begin : g_cell
		logic       cin;
		logic [3:0] nin;

		if (i == 0) begin : g_first
			assign cin = ctrl.bit_in;
			assign nin = 4'h0;
		end else begin : g_rest
			assign cin = carry[i-1];
			assign nin = digit[i-1];
		end

		cnf_bcd_cell u_cell (
			.clk       (clk),
			.ctrl      (ctrl),
			.load_nib  (load_word[i*4 +: 4]),
			.carry_in  (cin),
			.nib_in    (nin),
			.digit     (digit[i]),
			.carry_out (carry[i])
		);
	end

	assign top_digit = digit[cnf_pkg::NUM_CELLS-1];

endmodule
